// ===== rtl/core/rxc_pkg.sv =====
// Shared constants, types and the linearization table for the RGB to xy chromaticity core.
`timescale 1ns / 1ps
package rxc_pkg;

  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int CH_W   = 8;
  localparam int LIN_W  = 16;
  localparam int COEF_W = 20;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int XYZ_W  = PROD_W + 1;
  localparam int SUM_W  = 38;
  localparam int OUT_W  = 16;

  typedef logic [LIN_W-1:0]  lin_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef lin_t  lut_t [256];
  typedef coef_t row_t [3];
  typedef row_t  mat_t [3];

  // Matrix coefficients scaled by 10^6
  localparam mat_t COEF = '{
    '{20'd649926, 20'd103455, 20'd197109},
    '{20'd234327, 20'd743075, 20'd22598},
    '{20'd0,      20'd53077,  20'd1035763}
  };

  // Divider cell payload shared across the chain
  typedef struct packed {
    logic             zero;
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] rem_x;
    logic [SUM_W-1:0] rem_y;
  } div_t;

  localparam longint unsigned GAMMA_DEN = 64'd269025;
  localparam longint unsigned GAMMA_OFF = 64'd14025;
  localparam longint unsigned LIN_DEN   = 64'd329460;

  function automatic longint unsigned pow5_q31(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) p = (p * r) >> 31;
    return p;
  endfunction

  // sRGB transfer curve, Q0.16, evaluated at elaboration only
  function automatic lin_t lin_entry(longint unsigned c);
    longint unsigned t31, t2, lo, hi, mid, p, l;
    if (c * 100000 <= 4045 * 255) begin
      l = (c * 6553600 + 164730) / LIN_DEN;
      return lin_t'(l);
    end
    t31 = ((c * 1000 + GAMMA_OFF) << 31) / GAMMA_DEN;
    t2  = (t31 * t31) >> 31;
    lo  = 0;
    hi  = 64'd1 << 31;
    for (int k = 0; k < 40; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow5_q31(mid) <= t2) lo = mid;
        else hi = mid - 1;
      end
    end
    p = (t2 * lo) >> 31;
    l = (p + (64'd1 << 14)) >> 15;
    if (l > 65535) l = 65535;
    return lin_t'(l);
  endfunction

  function automatic lut_t build_lut();
    lut_t t;
    for (int c = 0; c < 256; c++) t[c] = lin_entry(longint'(c));
    return t;
  endfunction

  localparam lut_t LIN_LUT = build_lut();

endpackage

// ===== rtl/core/rgb_to_xy_chromaticity_core.sv =====
// Top level of the sRGB to CIE xy chromaticity core.
`timescale 1ns / 1ps
// Converts one 8-bit sRGB pixel per beat into CIE xy chromaticity, unsigned
// fixed point with OUT_FRAC_BITS fraction bits, saturating at the lesser of
// 2^OUT_FRAC_BITS-1 and 65535. Each channel is linearized by a 256-entry
// Q0.16 table, multiplied by a fixed wide-gamut matrix, and x = X/S, y = Y/S
// (S = X+Y+Z, rounded to nearest) are formed by a row of OUT_FRAC_BITS+1
// restoring-division cells, one quotient bit per cell. A black pixel gives
// x = y = 0 with m_tuser high. Throughput is one pixel per clock while m_tready
// does not stall the output; the pipeline is 5 front stages + OUT_FRAC_BITS+1
// cells + 1 output register. Every stage holds its own beat, so a stall on
// m_tready only backs up once the pipeline is full.
module rgb_to_xy_chromaticity_core #(
  parameter int OUT_FRAC_BITS = rxc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // chroma_x[15:0], chroma_y[31:16]
  output logic        m_tuser    // zero_sum
);
  import rxc_pkg::*;

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NCELL = QW;
  // saturation limit
  localparam longint unsigned LIM =
    (OUT_FRAC_BITS >= 16) ? 64'd65535 : ((64'd1 << OUT_FRAC_BITS) - 64'd1);

  // chain links: index 0 is the front output, index NCELL the last cell
  logic            c_valid [NCELL+1];
  logic            c_ready [NCELL+1];
  div_t            c_div   [NCELL+1];
  logic [QW-1:0]   c_wx    [NCELL+1];
  logic [QW-1:0]   c_wy    [NCELL+1];

  logic [QW-1:0]   sat_x, sat_y;

  rxc_front #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .out_valid  (c_valid[0]),
    .out_ready  (c_ready[0]),
    .out_div    (c_div[0]),
    .out_word_x (c_wx[0]),
    .out_word_y (c_wy[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rxc_div_cell #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (c_valid[k]),
      .in_ready   (c_ready[k]),
      .in_div     (c_div[k]),
      .in_word_x  (c_wx[k]),
      .in_word_y  (c_wy[k]),
      .out_valid  (c_valid[k+1]),
      .out_ready  (c_ready[k+1]),
      .out_div    (c_div[k+1]),
      .out_word_x (c_wx[k+1]),
      .out_word_y (c_wy[k+1])
    );
  end

  // After the last cell each word holds the full quotient
  assign sat_x = (c_wx[NCELL] > QW'(LIM)) ? QW'(LIM) : c_wx[NCELL];
  assign sat_y = (c_wy[NCELL] > QW'(LIM)) ? QW'(LIM) : c_wy[NCELL];

  // Output register
  assign c_ready[NCELL] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (c_ready[NCELL]) begin
      m_tvalid <= c_valid[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[NCELL]) begin
      m_tuser <= c_div[NCELL].zero;
      if (c_div[NCELL].zero) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {OUT_W'(sat_y), OUT_W'(sat_x)};
      end
    end
  end

endmodule

// ===== rtl/core/rxc_front.sv =====
// Front pipeline: linearization lookup, matrix, sums and divider seed.
`timescale 1ns / 1ps
module rxc_front #(
  parameter int OUT_FRAC_BITS = rxc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3*rxc_pkg::CH_W-1:0] in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rxc_pkg::div_t            out_div,
  output logic [OUT_FRAC_BITS:0]   out_word_x,
  output logic [OUT_FRAC_BITS:0]   out_word_y
);
  import rxc_pkg::*;

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NW = SUM_W + OUT_FRAC_BITS;

  logic [5:1] v;
  logic [6:1] rdy;

  lin_t                lin [3];
  logic [PROD_W-1:0]   prod [3][3];
  logic [XYZ_W-1:0]    xyz [3];
  logic [XYZ_W-1:0]    x4, y4;
  logic [SUM_W-1:0]    s4;
  logic [NW-1:0]       num_x, num_y;

  assign rdy[6] = out_ready;
  for (genvar k = 1; k <= 5; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  // no beat is taken while in reset
  assign in_ready  = rdy[1] && !rst;
  assign out_valid = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 5; k++) if (rdy[k]) v[k] <= v[k-1];
    end
  end

  // Stage 1: table lookup
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int j = 0; j < 3; j++) lin[j] <= LIN_LUT[in_data[j*CH_W +: CH_W]];
    end
  end

  // Stage 2: nine products
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          prod[i][j] <= PROD_W'(lin[j]) * PROD_W'(COEF[i][j]);
    end
  end

  // Stage 3: X, Y, Z
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++)
        xyz[i] <= XYZ_W'(prod[i][0]) + XYZ_W'(prod[i][1]) + XYZ_W'(prod[i][2]);
    end
  end

  // Stage 4: S
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      x4 <= xyz[0];
      y4 <= xyz[1];
      s4 <= SUM_W'(xyz[0]) + SUM_W'(xyz[1]) + SUM_W'(xyz[2]);
    end
  end

  // Stage 5: rounded numerators split into remainder seed and dividend bits
  assign num_x = (NW'(x4) << OUT_FRAC_BITS) + NW'(s4 >> 1);
  assign num_y = (NW'(y4) << OUT_FRAC_BITS) + NW'(s4 >> 1);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_div.zero  <= (s4 == '0);
      out_div.s     <= s4;
      out_div.rem_x <= SUM_W'(num_x[NW-1:QW]);
      out_div.rem_y <= SUM_W'(num_y[NW-1:QW]);
      out_word_x    <= num_x[QW-1:0];
      out_word_y    <= num_y[QW-1:0];
    end
  end

endmodule

// ===== rtl/core/rxc_div_cell.sv =====
// One restoring-division cell: one quotient bit for x and for y per beat.
`timescale 1ns / 1ps
module rxc_div_cell #(
  parameter int OUT_FRAC_BITS = rxc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rxc_pkg::div_t          in_div,
  input  logic [OUT_FRAC_BITS:0] in_word_x,
  input  logic [OUT_FRAC_BITS:0] in_word_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rxc_pkg::div_t          out_div,
  output logic [OUT_FRAC_BITS:0] out_word_x,
  output logic [OUT_FRAC_BITS:0] out_word_y
);
  import rxc_pkg::*;

  localparam int QW = OUT_FRAC_BITS + 1;

  logic [SUM_W:0]   tx, ty, shx, shy;
  logic             qx, qy;

  // word shifts dividend bits out at the top and quotient bits in at the bottom
  assign shx = {in_div.rem_x, in_word_x[QW-1]};
  assign shy = {in_div.rem_y, in_word_y[QW-1]};
  assign tx  = shx - {1'b0, in_div.s};
  assign ty  = shy - {1'b0, in_div.s};
  assign qx  = !tx[SUM_W];
  assign qy  = !ty[SUM_W];

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_div.zero  <= in_div.zero;
      out_div.s     <= in_div.s;
      out_div.rem_x <= qx ? tx[SUM_W-1:0] : shx[SUM_W-1:0];
      out_div.rem_y <= qy ? ty[SUM_W-1:0] : shy[SUM_W-1:0];
      out_word_x    <= {in_word_x[QW-2:0], qx};
      out_word_y    <= {in_word_y[QW-2:0], qy};
    end
  end

endmodule
